### rtl/itp_pkg.sv
`default_nettype none

package itp_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int HANDLE_W    = 16;
  localparam int LINE_W      = 16;

  localparam logic [2:0] KIND_OPERAND  = 3'd0;
  localparam logic [2:0] KIND_OPERATOR = 3'd1;
  localparam logic [2:0] KIND_OPEN     = 3'd2;
  localparam logic [2:0] KIND_CLOSE    = 3'd3;

  localparam logic [2:0] OP_ADD = 3'd3;
  localparam logic [2:0] OP_MAX = 3'd4;

  localparam logic [1:0] OUT_OPERAND  = 2'd0;
  localparam logic [1:0] OUT_OPERATOR = 2'd1;
  localparam logic [1:0] OUT_ERROR    = 2'd2;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_NO_OPEN  = 2'd1;
  localparam logic [1:0] ERR_NO_CLOSE = 2'd2;
  localparam logic [1:0] ERR_OVERFLOW = 2'd3;

  typedef enum logic [1:0] {
    SEL_OPERAND,
    SEL_TOP,
    SEL_ERROR
  } emit_sel_t;

  typedef struct packed {
    logic              paren;
    logic [2:0]        op;
    logic [LINE_W-1:0] line;
  } entry_t;

  typedef struct packed {
    logic      capture;
    logic      emit;
    emit_sel_t sel;
    logic [1:0] err;
    logic      pop;
    logic      push;
    logic      finish;
  } itp_cmd_t;

  typedef struct packed {
    logic       empty;
    logic       full;
    logic       top_paren;
    logic       top_pops;
    logic       can_emit;
    logic       finish_ok;
    logic [2:0] kind;
    logic       op_valid;
    logic       tok_last;
  } itp_sts_t;

  function automatic logic is_additive(input logic [2:0] op);
    return op >= OP_ADD;
  endfunction

endpackage

`default_nettype wire

### rtl/itp_ctrl.sv
`default_nettype none

module itp_ctrl
  import itp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire itp_sts_t sts,
  output itp_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_OPPOP    = 3'd2;
  localparam logic [2:0] S_PUSH     = 3'd3;
  localparam logic [2:0] S_CLOSE    = 3'd4;
  localparam logic [2:0] S_FLUSH    = 3'd5;
  localparam logic [2:0] S_FINISH   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        priority if (sts.kind == KIND_OPERAND) begin
          if (sts.can_emit) begin
            cmd.emit   = 1'b1;
            cmd.sel    = SEL_OPERAND;
            state_next = S_FLUSH;
          end
        end else if (sts.kind == KIND_OPERATOR && sts.op_valid) begin
          state_next = S_OPPOP;
        end else if (sts.kind == KIND_OPEN) begin
          state_next = S_PUSH;
        end else if (sts.kind == KIND_CLOSE) begin
          state_next = S_CLOSE;
        end else begin
          state_next = S_FLUSH;
        end
      end
      S_OPPOP: begin
        if (!sts.empty && !sts.top_paren && sts.top_pops) begin
          if (sts.can_emit) begin
            cmd.emit = 1'b1;
            cmd.sel  = SEL_TOP;
            cmd.pop  = 1'b1;
          end
        end else begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        if (sts.full) begin
          if (sts.can_emit) begin
            cmd.emit   = 1'b1;
            cmd.sel    = SEL_ERROR;
            cmd.err    = ERR_OVERFLOW;
            state_next = S_FLUSH;
          end
        end else begin
          cmd.push   = 1'b1;
          state_next = S_FLUSH;
        end
      end
      S_CLOSE: begin
        priority if (sts.empty) begin
          if (sts.can_emit) begin
            cmd.emit   = 1'b1;
            cmd.sel    = SEL_ERROR;
            cmd.err    = ERR_NO_OPEN;
            state_next = S_FLUSH;
          end
        end else if (sts.top_paren) begin
          cmd.pop    = 1'b1;
          state_next = S_FLUSH;
        end else begin
          if (sts.can_emit) begin
            cmd.emit = 1'b1;
            cmd.sel  = SEL_TOP;
            cmd.pop  = 1'b1;
          end
        end
      end
      S_FLUSH: begin
        if (sts.tok_last && !sts.empty) begin
          if (sts.can_emit) begin
            cmd.emit = 1'b1;
            cmd.sel  = SEL_TOP;
            cmd.pop  = 1'b1;
          end
        end else begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts.finish_ok) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/itp_dp.sv
`default_nettype none

module itp_dp
  import itp_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire itp_cmd_t            cmd,
  output itp_sts_t                 sts,
  input  wire logic [2:0]          token_kind,
  input  wire logic [2:0]          op_code,
  input  wire logic [HANDLE_W-1:0] operand_handle,
  input  wire logic [LINE_W-1:0]   source_line,
  input  wire logic                end_of_expr,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [1:0]               out_kind,
  output logic [2:0]               out_op,
  output logic [HANDLE_W-1:0]      out_handle,
  output logic [1:0]               error_code,
  output logic [LINE_W-1:0]        error_line,
  output logic                     last_of_run
);

  entry_t             stack_mem [STACK_DEPTH];
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_dec;
  logic [PTR_W-1:0]   top_idx;
  logic [PTR_W-1:0]   below_idx;
  logic [PTR_W-1:0]   push_idx;
  entry_t             top;
  entry_t             push_entry;

  logic [2:0]          tok_kind;
  logic [2:0]          tok_op;
  logic [HANDLE_W-1:0] tok_handle;
  logic [LINE_W-1:0]   tok_line;
  logic                tok_last;

  logic                pend_valid;
  logic [1:0]          pend_kind;
  logic [2:0]          pend_op;
  logic [HANDLE_W-1:0] pend_handle;
  logic [1:0]          pend_err;
  logic [LINE_W-1:0]   pend_line;

  logic [1:0]          new_kind;
  logic [2:0]          new_op;
  logic [HANDLE_W-1:0] new_handle;
  logic [1:0]          new_err;
  logic [LINE_W-1:0]   new_line;

  logic out_free;
  logic out_load;

  assign count_dec = count - CNT_W'(1);
  assign top_idx   = count_dec[PTR_W-1:0];
  assign below_idx = top_idx - PTR_W'(1);
  assign push_idx  = count[PTR_W-1:0];
  assign out_free  = !out_valid || out_ready;
  assign out_load  = (cmd.emit || cmd.finish) && pend_valid;

  always_comb begin
    push_entry.paren = (tok_kind == KIND_OPEN);
    push_entry.op    = tok_op;
    push_entry.line  = tok_line;
  end

  always_comb begin
    sts.empty     = (count == '0);
    sts.full      = (count == CNT_W'(STACK_DEPTH));
    sts.top_paren = top.paren;
    sts.top_pops  = !(is_additive(top.op) && !is_additive(tok_op));
    sts.can_emit  = !pend_valid || out_free;
    sts.finish_ok = !pend_valid || out_free;
    sts.kind      = tok_kind;
    sts.op_valid  = (tok_op <= OP_MAX);
    sts.tok_last  = tok_last;
  end

  always_comb begin
    new_kind   = OUT_OPERAND;
    new_op     = '0;
    new_handle = '0;
    new_err    = ERR_NONE;
    new_line   = '0;
    unique case (cmd.sel)
      SEL_OPERAND: begin
        new_handle = tok_handle;
      end
      SEL_TOP: begin
        if (top.paren) begin
          new_kind = OUT_ERROR;
          new_err  = ERR_NO_CLOSE;
          new_line = top.line;
        end else begin
          new_kind = OUT_OPERATOR;
          new_op   = top.op;
        end
      end
      SEL_ERROR: begin
        new_kind = OUT_ERROR;
        new_err  = cmd.err;
        new_line = tok_line;
      end
      default: begin
        new_kind = OUT_OPERAND;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.emit) begin
        pend_valid <= 1'b1;
      end else if (cmd.finish) begin
        pend_valid <= 1'b0;
      end
      if (cmd.pop) begin
        count <= count_dec;
      end else if (cmd.push) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  // The top entry is kept in a register: a push loads it directly, and a pop
  // loads the entry below from the stack memory.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      tok_kind   <= token_kind;
      tok_op     <= op_code;
      tok_handle <= operand_handle;
      tok_line   <= source_line;
      tok_last   <= end_of_expr;
    end
    if (cmd.push) begin
      stack_mem[push_idx] <= push_entry;
      top                 <= push_entry;
    end else if (cmd.pop) begin
      top <= stack_mem[below_idx];
    end
    if (cmd.emit) begin
      pend_kind   <= new_kind;
      pend_op     <= new_op;
      pend_handle <= new_handle;
      pend_err    <= new_err;
      pend_line   <= new_line;
    end
    if (out_load) begin
      out_kind    <= pend_kind;
      out_op      <= pend_op;
      out_handle  <= pend_handle;
      error_code  <= pend_err;
      error_line  <= pend_line;
      last_of_run <= cmd.finish;
    end
  end

  // The stack never holds more entries than it has room for.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(STACK_DEPTH))
    else $error("operator stack count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> count != '0)
    else $error("pop from an empty operator stack");

  a_push_notfull: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> count != CNT_W'(STACK_DEPTH))
    else $error("push onto a full operator stack");

  // A held result may only move on when the output register can take it.
  a_pend_move: assert property (@(posedge clk) disable iff (rst)
    ((cmd.emit || cmd.finish) && pend_valid) |-> out_free)
    else $error("held result overwrote an untaken output");

  a_finish_last: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && pend_valid) |=> (out_valid && last_of_run && !pend_valid))
    else $error("final result of a transaction not marked last");

endmodule

`default_nettype wire

### rtl/infix_to_postfix_converter_top.sv
// Channel  | Handshake             | Payload
// input    | in_valid / in_ready   | token_kind, op_code, operand_handle, source_line,
//          |                       | end_of_expr
// output   | out_valid / out_ready | out_kind, out_op, out_handle, error_code,
//          |                       | error_line, last_of_run
//
// A transaction passes through take, decode, flush check and finish. An open paren adds
// a push or overflow report, an operator a precedence check and a push, a close paren its
// paren pop or error report, and each popped or flushed stack entry a step of its own.
// Results leave one per cycle unless the output stalls; each is held in a pending register
// so that the final result of a transaction can be marked with last_of_run; reset empties
// the stack and drops them. A stalled output holds the sequencer; the next token is taken
// while the final result still waits in the output register.
`default_nettype none

module infix_to_postfix_converter_top
  import itp_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [2:0]          token_kind,
  input  wire logic [2:0]          op_code,
  input  wire logic [HANDLE_W-1:0] operand_handle,
  input  wire logic [LINE_W-1:0]   source_line,
  input  wire logic                end_of_expr,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [1:0]               out_kind,
  output logic [2:0]               out_op,
  output logic [HANDLE_W-1:0]      out_handle,
  output logic [1:0]               error_code,
  output logic [LINE_W-1:0]        error_line,
  output logic                     last_of_run
);

  itp_cmd_t cmd;
  itp_sts_t sts;

  itp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  itp_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .token_kind     (token_kind),
    .op_code        (op_code),
    .operand_handle (operand_handle),
    .source_line    (source_line),
    .end_of_expr    (end_of_expr),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_op         (out_op),
    .out_handle     (out_handle),
    .error_code     (error_code),
    .error_line     (error_line),
    .last_of_run    (last_of_run)
  );

endmodule

`default_nettype wire

### bench/infix_to_postfix_converter_checker.sv
`timescale 1ns / 1ps

module infix_to_postfix_converter_checker
  import itp_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                in_ready,
  input  wire logic [2:0]          token_kind,
  input  wire logic [2:0]          op_code,
  input  wire logic [HANDLE_W-1:0] operand_handle,
  input  wire logic [LINE_W-1:0]   source_line,
  input  wire logic                end_of_expr,
  input  wire logic                out_valid,
  input  wire logic                out_ready,
  input  wire logic [1:0]          out_kind,
  input  wire logic [2:0]          out_op,
  input  wire logic [HANDLE_W-1:0] out_handle,
  input  wire logic [1:0]          error_code,
  input  wire logic [LINE_W-1:0]   error_line,
  input  wire logic                last_of_run,
  output int                       mismatches,
  output int                       results_owed
);

  typedef struct packed {
    logic [1:0]          kind;
    logic [2:0]          op;
    logic [HANDLE_W-1:0] handle;
    logic [1:0]          err;
    logic [LINE_W-1:0]   line;
    logic                last;
  } postfix_tok_t;

  entry_t       op_stack [STACK_DEPTH];
  int           stack_fill;
  postfix_tok_t released_q[$];
  postfix_tok_t postfix_q[$];

  function automatic int bind_rank(input logic [2:0] op);
    return (op >= OP_ADD) ? 2 : 1;
  endfunction

  function automatic void release_tok(input logic [1:0] kind, input logic [2:0] op,
                                      input logic [HANDLE_W-1:0] handle,
                                      input logic [1:0] err,
                                      input logic [LINE_W-1:0] line);
    postfix_tok_t t;
    t.kind   = kind;
    t.op     = op;
    t.handle = handle;
    t.err    = err;
    t.line   = line;
    t.last   = 1'b0;
    released_q.insert(released_q.size(), t);
  endfunction

  function automatic void release_entry(input entry_t e);
    if (e.paren) begin
      release_tok(OUT_ERROR, 3'd0, '0, ERR_NO_CLOSE, e.line);
    end else begin
      release_tok(OUT_OPERATOR, e.op, '0, ERR_NONE, '0);
    end
  endfunction

  function automatic void stack_push(input entry_t e, input logic [LINE_W-1:0] line);
    if (stack_fill >= STACK_DEPTH) begin
      release_tok(OUT_ERROR, 3'd0, '0, ERR_OVERFLOW, line);
    end else begin
      op_stack[stack_fill] = e;
      stack_fill++;
    end
  endfunction

  function automatic void convert_token(input logic [2:0] kind, input logic [2:0] op,
                                        input logic [HANDLE_W-1:0] handle,
                                        input logic [LINE_W-1:0] line,
                                        input logic flush);
    entry_t       e;
    bit           found;
    postfix_tok_t t;
    released_q.delete();
    if (kind == KIND_OPERAND) begin
      release_tok(OUT_OPERAND, 3'd0, handle, ERR_NONE, '0);
    end else if (kind == KIND_OPERATOR && op <= OP_MAX) begin
      while (stack_fill > 0) begin
        e = op_stack[stack_fill-1];
        if (e.paren || bind_rank(e.op) > bind_rank(op)) break;
        release_entry(e);
        stack_fill--;
      end
      e.paren = 1'b0;
      e.op    = op;
      e.line  = line;
      stack_push(e, line);
    end else if (kind == KIND_OPEN) begin
      e.paren = 1'b1;
      e.op    = 3'd0;
      e.line  = line;
      stack_push(e, line);
    end else if (kind == KIND_CLOSE) begin
      found = 1'b0;
      while (stack_fill > 0) begin
        stack_fill--;
        e = op_stack[stack_fill];
        if (e.paren) begin
          found = 1'b1;
          break;
        end
        release_entry(e);
      end
      if (!found) release_tok(OUT_ERROR, 3'd0, '0, ERR_NO_OPEN, line);
    end
    if (flush) begin
      while (stack_fill > 0) begin
        stack_fill--;
        release_entry(op_stack[stack_fill]);
      end
    end
    for (int i = 0; i < released_q.size(); i++) begin
      t      = released_q[i];
      t.last = (i == released_q.size() - 1);
      postfix_q.insert(postfix_q.size(), t);
    end
  endfunction

  function automatic void check_field(input string name, input logic [15:0] exp_v,
                                      input logic [15:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, got_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : watch
    postfix_tok_t want;
    if (rst) begin
      stack_fill = 0;
      postfix_q.delete();
      mismatches = 0;
      results_owed <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (postfix_q.size() == 0) begin
          $error("out_kind: expected no transaction, actual %0d", out_kind);
          mismatches++;
        end else begin
          want = postfix_q.pop_front();
          check_field("out_kind", 16'(want.kind), 16'(out_kind));
          check_field("out_op", 16'(want.op), 16'(out_op));
          check_field("out_handle", want.handle, out_handle);
          check_field("error_code", 16'(want.err), 16'(error_code));
          check_field("error_line", want.line, error_line);
          check_field("last_of_run", 16'(want.last), 16'(last_of_run));
        end
      end
      if (in_valid && in_ready) begin
        convert_token(token_kind, op_code, operand_handle, source_line, end_of_expr);
      end
      results_owed <= postfix_q.size();
    end
  end

endmodule

### bench/infix_to_postfix_converter_top_tb.sv
`timescale 1ns / 1ps

module infix_to_postfix_converter_top_tb;
  import itp_pkg::*;

  localparam int ITEM_TARGET  = 430;
  localparam int QUIET_TAIL   = 60;
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT  = 600000;

  localparam logic [2:0] KIND_PUNCT    = 3'd4;
  localparam logic [2:0] KIND_RSVD_MIN = 3'd5;
  localparam logic [2:0] KIND_RSVD_MAX = 3'd7;
  localparam logic [2:0] OP_MUL        = 3'd0;
  localparam logic [2:0] OP_DIV        = 3'd1;
  localparam logic [2:0] OP_MOD        = 3'd2;
  localparam logic [2:0] OP_SUB        = 3'd4;
  localparam logic [2:0] OP_RSVD       = 3'd7;

  typedef struct packed {
    logic [2:0]          kind;
    logic [2:0]          op;
    logic [HANDLE_W-1:0] handle;
    logic [LINE_W-1:0]   line;
    logic                eoe;
  } tok_t;

  logic                clk            = 1'b0;
  logic                rst            = 1'b1;
  logic                in_valid       = 1'b0;
  logic [2:0]          token_kind     = '0;
  logic [2:0]          op_code        = '0;
  logic [HANDLE_W-1:0] operand_handle = '0;
  logic [LINE_W-1:0]   source_line    = '0;
  logic                end_of_expr    = 1'b0;
  logic                out_ready      = 1'b0;
  logic                in_ready;
  logic                out_valid;
  logic [1:0]          out_kind;
  logic [2:0]          out_op;
  logic [HANDLE_W-1:0] out_handle;
  logic [1:0]          error_code;
  logic [LINE_W-1:0]   error_line;
  logic                last_of_run;

  int   mismatches;
  int   results_owed;
  bit   quiet      = 1'b0;
  int   stall_left = 0;
  int   cycles     = 0;
  int   fed        = 0;
  tok_t expr_q[$];

  infix_to_postfix_converter_top u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .token_kind     (token_kind),
    .op_code        (op_code),
    .operand_handle (operand_handle),
    .source_line    (source_line),
    .end_of_expr    (end_of_expr),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_op         (out_op),
    .out_handle     (out_handle),
    .error_code     (error_code),
    .error_line     (error_line),
    .last_of_run    (last_of_run)
  );

  infix_to_postfix_converter_checker u_chk (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .token_kind     (token_kind),
    .op_code        (op_code),
    .operand_handle (operand_handle),
    .source_line    (source_line),
    .end_of_expr    (end_of_expr),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_op         (out_op),
    .out_handle     (out_handle),
    .error_code     (error_code),
    .error_line     (error_line),
    .last_of_run    (last_of_run),
    .mismatches     (mismatches),
    .results_owed   (results_owed)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic void append_tok(input tok_t t);
    expr_q.insert(expr_q.size(), t);
  endfunction

  function automatic tok_t make_tok(input logic [2:0] kind, input logic [2:0] op);
    tok_t t;
    t.kind   = kind;
    t.op     = op;
    t.handle = 16'($urandom_range(0, 65535));
    t.line   = 16'($urandom_range(0, 65535));
    t.eoe    = 1'b0;
    return t;
  endfunction

  function automatic void add_tok(input logic [2:0] kind, input logic [2:0] op,
                                  input logic [15:0] handle, input logic [15:0] line,
                                  input logic eoe);
    tok_t t;
    t.kind   = kind;
    t.op     = op;
    t.handle = handle;
    t.line   = line;
    t.eoe    = eoe;
    append_tok(t);
  endfunction

  function automatic void mark_end();
    tok_t t;
    t     = expr_q[expr_q.size() - 1];
    t.eoe = 1'b1;
    expr_q[expr_q.size() - 1] = t;
  endfunction

  function automatic logic [2:0] any_op();
    return 3'($urandom_range(0, 7));
  endfunction

  function automatic void build_expr(input int max_nest, input int len);
    int depth;
    int steps;
    bit want_operand;
    depth        = 0;
    steps        = 0;
    want_operand = 1'b1;
    forever begin
      if (want_operand) begin
        if (depth < max_nest && steps < len && $urandom_range(0, 3) == 0) begin
          append_tok(make_tok(KIND_OPEN, any_op()));
          depth++;
        end else begin
          append_tok(make_tok(KIND_OPERAND, any_op()));
          want_operand = 1'b0;
        end
      end else if (depth > 0 && (steps >= len || $urandom_range(0, 2) == 0)) begin
        append_tok(make_tok(KIND_CLOSE, any_op()));
        depth--;
      end else if (steps < len) begin
        append_tok(make_tok(KIND_OPERATOR, 3'($urandom_range(0, OP_MAX))));
        want_operand = 1'b1;
      end else begin
        break;
      end
      steps++;
    end
  endfunction

  function automatic void build_nest(input int nest);
    for (int i = 0; i < nest; i++) append_tok(make_tok(KIND_OPEN, any_op()));
    build_expr(2, $urandom_range(1, 4));
    for (int i = $urandom_range(0, nest); i > 0; i--) begin
      append_tok(make_tok(KIND_CLOSE, any_op()));
    end
    mark_end();
  endfunction

  task automatic send_tok(input tok_t t);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    token_kind     <= t.kind;
    op_code        <= t.op;
    operand_handle <= t.handle;
    source_line    <= t.line;
    end_of_expr    <= t.eoe;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    fed++;
  endtask

  task automatic send_expr();
    for (int i = 0; i < expr_q.size(); i++) send_tok(expr_q[i]);
    expr_q.delete();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int   mode;
    int   pos;
    tok_t t;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // a * (b + c - d) / e % f, then a close with no open, then ignored tokens, an unclosed open and a lone operator
    add_tok(KIND_OPERAND, OP_MUL, 16'h0000, 16'h0000, 1'b0);
    add_tok(KIND_OPERATOR, OP_MUL, 16'h0000, 16'h0000, 1'b0);
    add_tok(KIND_OPEN, OP_MUL, 16'hFFFF, 16'hFFFF, 1'b0);
    add_tok(KIND_OPERAND, OP_RSVD, 16'hFFFF, 16'hFFFF, 1'b0);
    add_tok(KIND_OPERATOR, OP_ADD, 16'h1111, 16'h0010, 1'b0);
    add_tok(KIND_OPERAND, OP_ADD, 16'h2222, 16'h0011, 1'b0);
    add_tok(KIND_OPERATOR, OP_SUB, 16'h3333, 16'h0012, 1'b0);
    add_tok(KIND_OPERAND, OP_SUB, 16'h4444, 16'h0013, 1'b0);
    add_tok(KIND_CLOSE, OP_MUL, 16'h0000, 16'h0014, 1'b0);
    add_tok(KIND_OPERATOR, OP_DIV, 16'h5555, 16'h0015, 1'b0);
    add_tok(KIND_OPERAND, OP_DIV, 16'h6666, 16'h0016, 1'b0);
    add_tok(KIND_OPERATOR, OP_MOD, 16'h7777, 16'h0017, 1'b0);
    add_tok(KIND_OPERAND, OP_MOD, 16'h8888, 16'h0018, 1'b1);
    add_tok(KIND_OPERAND, OP_MUL, 16'hA5A5, 16'h0020, 1'b0);
    add_tok(KIND_OPERATOR, OP_SUB, 16'h0000, 16'h0021, 1'b0);
    add_tok(KIND_OPERAND, OP_MUL, 16'h5A5A, 16'h0022, 1'b0);
    add_tok(KIND_CLOSE, OP_MUL, 16'h0000, 16'hFFFF, 1'b1);
    add_tok(KIND_PUNCT, OP_MUL, 16'hFFFF, 16'h0030, 1'b0);
    add_tok(KIND_RSVD_MAX, OP_RSVD, 16'hFFFF, 16'hFFFF, 1'b0);
    add_tok(KIND_OPERATOR, OP_RSVD, 16'h0000, 16'h0031, 1'b0);
    add_tok(KIND_OPEN, OP_ADD, 16'h0000, 16'h1234, 1'b0);
    add_tok(KIND_OPERAND, OP_ADD, 16'hBEEF, 16'h0040, 1'b0);
    add_tok(KIND_RSVD_MIN, OP_MUL, 16'h0000, 16'h0041, 1'b1);
    add_tok(KIND_OPERATOR, OP_ADD, 16'h0000, 16'h0050, 1'b1);
    send_expr();

    // Hold the input off until every result of the directed part is out.
    wait_drained();

    // Seventeen open parens: the last one overflows the stack.
    build_nest(STACK_DEPTH + 1);
    send_expr();

    while (fed < ITEM_TARGET) begin
      if (fed >= ITEM_TARGET - QUIET_TAIL) quiet = 1'b1;
      mode = $urandom_range(0, 9);
      if (mode == 0) begin
        for (int i = $urandom_range(1, 4); i > 0; i--) begin
          t     = make_tok(3'($urandom_range(0, 7)), any_op());
          t.eoe = 1'($urandom_range(0, 1));
          append_tok(t);
        end
      end else if (mode == 1) begin
        build_nest($urandom_range(12, 18));
      end else if (mode == 2) begin
        build_expr(4, $urandom_range(2, 10));
        pos = $urandom_range(0, expr_q.size() - 1);
        if ($urandom_range(0, 1) == 0) begin
          expr_q.delete(pos);
        end else begin
          expr_q.insert(pos, make_tok(KIND_CLOSE, any_op()));
        end
        if (expr_q.size() > 0 && $urandom_range(0, 1) == 0) mark_end();
      end else begin
        build_expr(4, $urandom_range(1, 12));
        if ($urandom_range(0, 5) == 0) begin
          pos = $urandom_range(0, expr_q.size());
          expr_q.insert(pos, make_tok(3'($urandom_range(KIND_PUNCT, KIND_RSVD_MAX)),
                                      any_op()));
        end
        mark_end();
      end
      send_expr();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
